### hw/rtl/spta_pkg.sv
package spta_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic absorb;      // merge or append the presented term
    logic drain_step;  // the current table entry was transferred
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drain_done;  // the entry being shown is the final one of the run
  } status_t;

endpackage

### hw/rtl/spta_ctrl.sv
module spta_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             term_valid,
  input  logic             last_term,
  input  logic             entry_ready,
  input  spta_pkg::status_t status,
  output logic             term_ready,
  output logic             entry_valid,
  output spta_pkg::cmd_t   cmd
);
  import spta_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (term_valid && last_term) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (entry_ready && status.drain_done) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    term_ready      = 1'b0;
    entry_valid     = 1'b0;
    cmd.absorb      = 1'b0;
    cmd.drain_step  = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        term_ready = 1'b1;
        cmd.absorb = term_valid;
      end
      ST_DRAIN: begin
        entry_valid    = 1'b1;
        cmd.drain_step = entry_ready;
      end
      default: begin
        term_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/spta_dp.sv
module spta_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  spta_pkg::cmd_t        cmd,
  input  logic signed [31:0]    coefficient,
  input  logic signed [15:0]    exponent,
  output spta_pkg::status_t     status,
  output logic signed [31:0]    sum_coefficient,
  output logic signed [15:0]    sum_exponent,
  output logic                  last_entry,
  output logic                  overflowed
);
  import spta_pkg::*;

  logic signed [15:0] exp_store  [TABLE_DEPTH];
  logic signed [31:0] coef_store [TABLE_DEPTH];
  logic [CNT_W-1:0]   entry_count;
  logic               overflow_seen;
  logic [IDX_W-1:0]   drain_idx;

  logic [TABLE_DEPTH-1:0] match_vec;
  logic                   any_match;
  logic                   full;
  logic                   drain_done;

  // Every occupied entry compares its exponent against the term at once.
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      match_vec[k] = (CNT_W'(k) < entry_count) && (exp_store[k] == exponent);
    end
  end

  assign any_match  = |match_vec;
  assign full       = (entry_count == CNT_W'(TABLE_DEPTH));
  assign drain_done = ((CNT_W'(drain_idx) + CNT_W'(1)) == entry_count);

  always_ff @(posedge clk) begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (cmd.absorb) begin
        if (match_vec[k]) begin
          coef_store[k] <= coef_store[k] + coefficient;
        end else if (!any_match && !full && (entry_count == CNT_W'(k))) begin
          exp_store[k]  <= exponent;
          coef_store[k] <= coefficient;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      overflow_seen <= 1'b0;
      drain_idx     <= '0;
    end else begin
      if (cmd.absorb && !any_match) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end
      if (cmd.drain_step) begin
        if (drain_done) begin
          entry_count   <= '0;
          overflow_seen <= 1'b0;
          drain_idx     <= '0;
        end else begin
          drain_idx <= drain_idx + IDX_W'(1);
        end
      end
    end
  end

  assign status.drain_done = drain_done;
  assign sum_coefficient   = coef_store[drain_idx];
  assign sum_exponent      = exp_store[drain_idx];
  assign last_entry        = drain_done;
  assign overflowed        = overflow_seen;

endmodule

### hw/rtl/sparse_polynomial_term_accumulator.sv
// Sparse polynomial term accumulator. Terms (coefficient, exponent) are
// taken one per cycle while the block collects: every stored exponent is
// compared with the incoming one in the same cycle, so a matching term adds
// its coefficient into that entry (32-bit wrap) and a new exponent is
// appended in order of first appearance. With the table full, a new exponent
// is dropped and the sticky overflow flag is set; matches still merge. The
// transfer of a term with last_term high is merged first, and from the next
// cycle on the block shows the table as a run of entries, one per cycle
// while entry_ready is high, with last_entry on the final one and overflowed
// the same on all of them. A run holds between one and sixteen entries, and
// no term is taken until the final entry has been transferred. After the
// run the table and the flag are empty again. Zero sums are kept as entries.
module sparse_polynomial_term_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               term_valid,
  output logic               term_ready,
  input  logic signed [31:0] coefficient,
  input  logic signed [15:0] exponent,
  input  logic               last_term,
  output logic               entry_valid,
  input  logic               entry_ready,
  output logic signed [31:0] sum_coefficient,
  output logic signed [15:0] sum_exponent,
  output logic               last_entry,
  output logic               overflowed
);
  import spta_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller decides when terms are taken and when entries are shown.
  spta_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .term_valid  (term_valid),
    .last_term   (last_term),
    .entry_ready (entry_ready),
    .status      (status),
    .term_ready  (term_ready),
    .entry_valid (entry_valid),
    .cmd         (cmd)
  );

  // The datapath holds the table, the parallel compare and the drain pointer.
  spta_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .coefficient     (coefficient),
    .exponent        (exponent),
    .status          (status),
    .sum_coefficient (sum_coefficient),
    .sum_exponent    (sum_exponent),
    .last_entry      (last_entry),
    .overflowed      (overflowed)
  );

endmodule

### test/tb_sparse_polynomial_term_accumulator.sv
module tb_sparse_polynomial_term_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import spta_pkg::TABLE_DEPTH;

  // Generous bound on the whole run. The slowest correct run sends about 150
  // terms, each after an optional gap, and drains at most 16 entries per data
  // set, each of which may wait out a receiver stall.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_SETTLE  = 20;
  localparam int RANDOM_TERMS  = 90;
  localparam int REPORT_LIMIT  = 10;

  // One entry of an emitted run, as the block should present it.
  typedef struct packed {
    logic signed [31:0] coef;
    logic signed [15:0] expo;
    logic               last;
    logic               ovf;
  } run_entry_t;

  logic               clk;
  logic               rst;
  logic               term_valid;
  logic               term_ready;
  logic signed [31:0] coefficient;
  logic signed [15:0] exponent;
  logic               last_term;
  logic               entry_valid;
  logic               entry_ready;
  logic signed [31:0] sum_coefficient;
  logic signed [15:0] sum_exponent;
  logic               last_entry;
  logic               overflowed;

  sparse_polynomial_term_accumulator uut (
    .clk             (clk),
    .rst             (rst),
    .term_valid      (term_valid),
    .term_ready      (term_ready),
    .coefficient     (coefficient),
    .exponent        (exponent),
    .last_term       (last_term),
    .entry_valid     (entry_valid),
    .entry_ready     (entry_ready),
    .sum_coefficient (sum_coefficient),
    .sum_exponent    (sum_exponent),
    .last_entry      (last_entry),
    .overflowed      (overflowed)
  );

  // Shadow copy of the block's term table. Only entries below term_count
  // are ever read, so the table needs no reset of its own.
  logic [15:0] term_exponent [TABLE_DEPTH];
  logic [31:0] term_coefficient [TABLE_DEPTH];
  int          term_count;
  logic        term_overflow;

  // Entries that the block still owes us, oldest first.
  run_entry_t  pending_entries[$];

  int          mismatch_count;
  int          cycle_count;
  int          stall_left;
  run_entry_t  seen_entry;
  run_entry_t  want_entry;

  // Idling switches. The random test turns them off now and then so that
  // some data sets run back to back with no gaps on either side.
  bit          term_gaps_on;
  bit          entry_stalls_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Most gaps are zero or short; about one in ten is long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Coefficients lean toward the extremes and toward small values, so that
  // sums wrap in both directions and cancel to zero now and then.
  function automatic logic [31:0] pick_coefficient();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Folds one transferred term into the shadow table. A matching exponent
  // merges even when the table is full; a new exponent with the table full
  // is dropped and marks the run as overflowed. The last term of a data set
  // is folded first, then the whole table becomes the expected run.
  task automatic fold_term(input logic [31:0] coef, input logic [15:0] expo,
                           input logic last);
    int k;
    bit hit;
    run_entry_t e;
    hit = 1'b0;
    for (k = 0; k < term_count; k++) begin
      if (term_exponent[k] == expo) begin
        term_coefficient[k] = term_coefficient[k] + coef;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      if (term_count < TABLE_DEPTH) begin
        term_exponent[term_count]    = expo;
        term_coefficient[term_count] = coef;
        term_count++;
      end else begin
        term_overflow = 1'b1;
      end
    end
    if (last) begin
      for (k = 0; k < term_count; k++) begin
        e.coef = term_coefficient[k];
        e.expo = term_exponent[k];
        e.last = (k == term_count - 1);
        e.ovf  = term_overflow;
        pending_entries.push_back(e);
      end
      term_count    = 0;
      term_overflow = 1'b0;
    end
  endtask

  // Presents one term after an optional gap and holds it until the block
  // takes it. Inputs change on the falling edge only; term_ready is read
  // right at the rising edge, before the block's own updates land.
  task automatic send_term(input logic [31:0] coef, input logic [15:0] expo,
                           input logic last);
    int gap;
    gap = term_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      term_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    term_valid  = 1'b1;
    coefficient = coef;
    exponent    = expo;
    last_term   = last;
    do @(posedge clk); while (!term_ready);
    fold_term(coef, expo, last);
  endtask

  // Only the first few failures are described in full; the rest are counted.
  task automatic report_failure(input string what, input run_entry_t want,
                                input run_entry_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected coef=%0d expo=%0d last=%0b ovf=%0b,",
               $realtime, what, want.coef, want.expo, want.last, want.ovf);
      $display("    got coef=%0d expo=%0d last=%0b ovf=%0b",
               got.coef, got.expo, got.last, got.ovf);
    end
  endtask

  // Receiver side: entry_ready is high most of the time, with random stalls
  // that start on any cycle, including the middle of a run.
  initial begin
    entry_ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        entry_ready = 1'b0;
        stall_left--;
      end else begin
        entry_ready = 1'b1;
        if (entry_stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Every entry transfer is compared field by field with the oldest
  // expectation. An entry with nothing expected is a failure too.
  always @(posedge clk) begin
    if (!rst && entry_valid && entry_ready) begin
      seen_entry.coef = sum_coefficient;
      seen_entry.expo = sum_exponent;
      seen_entry.last = last_entry;
      seen_entry.ovf  = overflowed;
      if (pending_entries.size() == 0) begin
        want_entry = '0;
        report_failure("entry with nothing expected", want_entry, seen_entry);
      end else begin
        want_entry = pending_entries.pop_front();
        if (seen_entry !== want_entry) begin
          report_failure("entry mismatch", want_entry, seen_entry);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still expected",
               cycle_count, pending_entries.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Two data sets of one term each, at the top and the bottom of both ranges: each a run of one entry.
  task automatic test_single_extreme();
    send_term(32'h7FFF_FFFF, 16'h7FFF, 1'b1);
    send_term(32'h8000_0000, 16'h8000, 1'b1);
  endtask

  // Merges that wrap upward and downward, a sum that cancels to zero and
  // stays in the table, and a zero exponent with a zero coefficient.
  task automatic test_merge_wrap_zero();
    send_term(32'h7FFF_FFFF, 16'h0005, 1'b0);
    send_term(32'h0000_0001, 16'h0005, 1'b0);
    send_term(32'h8000_0000, 16'h8000, 1'b0);
    send_term(32'h8000_0000, 16'h8000, 1'b0);
    send_term(32'h0000_0000, 16'h0000, 1'b0);
    send_term(32'h0000_0001, 16'h7FFF, 1'b0);
    send_term(32'hFFFF_FFFF, 16'h7FFF, 1'b1);
  endtask

  // Fills the table, then offers a new exponent (dropped), a match that must
  // still merge, and a last term with a new exponent that is also dropped.
  // The run holds all sixteen entries with the overflow flag set; the next
  // data set shows the flag cleared again.
  task automatic test_full_table();
    int k;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      send_term(32'(k * 3 + 1), 16'h8000 + 16'(k * 16'h0FFF), 1'b0);
    end
    send_term(32'h1234_5678, 16'h0001, 1'b0);
    send_term(32'h0000_0003, 16'h8000, 1'b0);
    send_term(32'h0000_0009, 16'h0002, 1'b1);
    send_term(32'h0000_0042, 16'h0001, 1'b1);
  endtask

  // Random data sets. Exponents come mostly from a small pool per set, so
  // merges are common and a pool wider than the table overflows it; a few
  // exponents are drawn from the whole range. Idling is switched per set.
  task automatic test_random_sets();
    logic [15:0] exp_pool [20];
    int pool_size;
    int set_len;
    int sent;
    int i;
    logic [15:0] expo;
    sent = 0;
    while (sent < RANDOM_TERMS) begin
      term_gaps_on    = ($urandom_range(0, 3) != 0);
      entry_stalls_on = ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(1, 20);
      for (i = 0; i < 20; i++) exp_pool[i] = 16'($urandom_range(0, 16'hFFFF));
      set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 30)
                                            : $urandom_range(1, 10);
      for (i = 0; i < set_len; i++) begin
        expo = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                           : exp_pool[$urandom_range(0, pool_size - 1)];
        send_term(pick_coefficient(), expo, i == set_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    term_valid      = 1'b0;
    coefficient     = '0;
    exponent        = '0;
    last_term       = 1'b0;
    term_count      = 0;
    term_overflow   = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    term_gaps_on    = 1'b1;
    entry_stalls_on = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_extreme();
    test_merge_wrap_zero();
    test_full_table();
    test_random_sets();

    @(negedge clk);
    term_valid = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
